// File: hdl/cssr_pkg.sv
// ----------------------------------------------------------------------------
// Clipped span setup package
// Shared widths, codes, coordinate types and the box clip helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cssr_pkg;

    localparam int C_WIDTH   = 640;
    localparam int C_HEIGHT  = 480;
    localparam int C_CW      = 18;
    localparam int C_LANES   = 4;
    localparam int C_LW      = $clog2(C_LANES);
    localparam int C_IN_DW   = 88;
    localparam int C_IN_UW   = 3;
    localparam int C_OUT_DW  = 64;
    localparam int C_IDX_W   = 2;
    localparam int C_CFG_DW  = 10;

    localparam logic [9:0] C_WIN_W_RST = 10'd640;
    localparam logic [8:0] C_WIN_H_RST = 9'd480;

    typedef logic signed [C_CW-1:0] t_crd;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_LINE,
        CMD_FILL,
        CMD_OUTLINE
    } t_cmd;

    typedef enum logic [C_IDX_W-1:0] {
        REG_WIN_X,
        REG_WIN_Y,
        REG_WIN_W,
        REG_WIN_H
    } t_reg_idx;

    typedef struct packed {
        t_crd xl;
        t_crd yl;
        t_crd xh;
        t_crd yh;
    } t_box;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    typedef struct packed {
        logic vis;
        t_box box;
    } t_clip;

    function automatic t_box order_box(t_crd xa, t_crd ya, t_crd xb, t_crd yb);
        t_box b;
        b.xl = (xa < xb) ? xa : xb;
        b.xh = (xa < xb) ? xb : xa;
        b.yl = (ya < yb) ? ya : yb;
        b.yh = (ya < yb) ? yb : ya;
        return b;
    endfunction

    // Clips an ordered box to [0, w-1] x [0, h-1].
    function automatic t_clip clip_box(t_box b, t_crd w, t_crd h);
        t_clip c;
        t_crd  wm1;
        t_crd  hm1;
        wm1   = w - t_crd'(1);
        hm1   = h - t_crd'(1);
        c.box = b;
        c.vis = !(b.xh < t_crd'(0) || b.yh < t_crd'(0) || b.xl >= w || b.yl >= h);
        if (b.xl < t_crd'(0)) c.box.xl = t_crd'(0);
        if (b.yl < t_crd'(0)) c.box.yl = t_crd'(0);
        if (b.xh > wm1) c.box.xh = wm1;
        if (b.yh > hm1) c.box.yh = hm1;
        c.vis = c.vis && (c.box.xl <= c.box.xh) && (c.box.yl <= c.box.yh);
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/clipped_span_rect_setup_top.sv
// ----------------------------------------------------------------------------
// Clipped span setup: an input transfer reaches its descriptors through registered stages.
// A command enters every cycle unless the pipeline stalls; one with n visible span blocks
// holds the output register until its n lanes are shown one by one (an outline up to four).
// Synchronous active-low reset empties the pipeline and sets the window to 0, 0, 640, 480.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_span_rect_setup_top #(
    parameter int WIDTH  = cssr_pkg::C_WIDTH,
    parameter int HEIGHT = cssr_pkg::C_HEIGHT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_first, y_first, x_second, y_second, red, green, blue
    input  logic [cssr_pkg::C_IN_DW-1:0]  s_axis_tdata,
    // cmd, window_mode
    input  logic [cssr_pkg::C_IN_UW-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // base_addr, run_length, row_count, span_red, span_green, span_blue
    output logic [cssr_pkg::C_OUT_DW-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cssr_pkg::C_IDX_W-1:0]  i_cfg_index,
    input  logic [cssr_pkg::C_CFG_DW-1:0] i_cfg_data
);
    import cssr_pkg::*;

    localparam int   XW   = $clog2(WIDTH);
    localparam int   YW   = $clog2(HEIGHT);
    localparam int   PW   = XW + YW + 1;
    localparam t_crd SW   = t_crd'(WIDTH);
    localparam t_crd SH   = t_crd'(HEIGHT);
    localparam t_crd SHM1 = t_crd'(HEIGHT - 1);

    logic [9:0] r_win_x;
    logic [8:0] r_win_y;
    logic [9:0] r_win_w;
    logic [8:0] r_win_h;
    t_crd       w_wx, w_wy, w_ww, w_wh;

    logic [8:1] r_v;
    logic [8:1] w_rdy;

    t_cmd               r_cmd1;
    logic               r_rel1;
    logic signed [15:0] r_xf1, r_yf1, r_xs1, r_ys1;
    t_color             r_col1;

    t_box [C_LANES-1:0] n_box2, r_box2;
    logic [C_LANES-1:0] n_en2, r_en2;
    logic               r_rel2;
    t_color             r_col2;

    t_box [C_LANES-1:0] n_box3, r_box3;
    logic [C_LANES-1:0] n_en3, r_en3;
    logic               r_rel3;
    t_color             r_col3;

    t_box [C_LANES-1:0] n_box4, r_box4;
    logic [C_LANES-1:0] r_en4;
    t_color             r_col4;

    t_box [C_LANES-1:0] n_box5, r_box5;
    logic [C_LANES-1:0] n_en5, r_en5;
    t_color             r_col5;

    logic [C_LANES-1:0][XW-1:0] n_x6, r_x6;
    logic [C_LANES-1:0][YW-1:0] n_row6, r_row6;
    logic [C_LANES-1:0][9:0]    n_run6, r_run6;
    logic [C_LANES-1:0][8:0]    n_rows6, r_rows6;
    logic [C_LANES-1:0]         r_en6;
    t_color                     r_col6;

    logic [C_LANES-1:0][PW-1:0] n_prod7, r_prod7;
    logic [C_LANES-1:0][XW-1:0] r_x7;
    logic [C_LANES-1:0][9:0]    r_run7;
    logic [C_LANES-1:0][8:0]    r_rows7;
    logic [C_LANES-1:0]         r_en7;
    t_color                     r_col7;

    logic [C_LANES-1:0][20:0]   n_base8, r_base8;
    logic [C_LANES-1:0][9:0]    r_run8;
    logic [C_LANES-1:0][8:0]    r_rows8;
    logic [C_LANES-1:0]         r_m8;
    t_color                     r_col8;

    logic [C_LW-1:0]    w_sel;
    logic [C_LANES-1:0] w_rest;
    logic               w_xfer;
    logic               w_done8;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x <= '0;
            r_win_y <= '0;
            r_win_w <= C_WIN_W_RST;
            r_win_h <= C_WIN_H_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_WIN_X: r_win_x <= i_cfg_data;
                REG_WIN_Y: r_win_y <= i_cfg_data[8:0];
                REG_WIN_W: r_win_w <= i_cfg_data;
                REG_WIN_H: r_win_h <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign w_wx = {8'd0, r_win_x};
    assign w_wy = {9'd0, r_win_y};
    assign w_ww = {8'd0, r_win_w};
    assign w_wh = {9'd0, r_win_h};

    // Stall chain: a stage takes new data when it is empty or its content moves on.
    always_comb begin
        w_rdy[8] = !r_v[8] || w_done8;
        for (int k = 1; k < 8; k++) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end
    assign s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) r_v[1] <= s_axis_tvalid;
            for (int k = 2; k <= 8; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Split each command into up to four boxes with ordered corners.
    always_comb begin
        t_crd xf, yf, xs, ys;
        xf     = t_crd'(r_xf1);
        yf     = t_crd'(r_yf1);
        xs     = t_crd'(r_xs1);
        ys     = t_crd'(r_ys1);
        n_box2 = '0;
        n_en2  = '0;
        case (r_cmd1)
            CMD_PIXEL: begin
                n_box2[0] = order_box(xf, yf, xf, yf);
                n_en2     = 4'b0001;
            end
            CMD_LINE: begin
                n_box2[0] = order_box(xf, yf, xs, ys);
                n_en2     = {3'b000, (yf == ys) || (xf == xs)};
            end
            CMD_FILL: begin
                n_box2[0] = order_box(xf, yf, xs, ys);
                n_en2     = 4'b0001;
            end
            CMD_OUTLINE: begin
                n_box2[0] = order_box(xf, yf, xs, yf);
                n_box2[1] = order_box(xf, ys, xs, ys);
                n_box2[2] = order_box(xf, yf, xf, ys);
                n_box2[3] = order_box(xs, yf, xs, ys);
                n_en2     = 4'b1111;
            end
            default: begin
                n_en2 = '0;
            end
        endcase
    end

    always_comb begin
        t_clip c;
        for (int i = 0; i < C_LANES; i++) begin
            c = clip_box(r_box2[i], w_ww, w_wh);
            if (r_rel2) begin
                n_box3[i] = c.box;
                n_en3[i]  = r_en2[i] && c.vis;
            end else begin
                n_box3[i] = r_box2[i];
                n_en3[i]  = r_en2[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < C_LANES; i++) begin
            n_box4[i] = r_box3[i];
            if (r_rel3) begin
                n_box4[i].xl = r_box3[i].xl + w_wx;
                n_box4[i].xh = r_box3[i].xh + w_wx;
                n_box4[i].yl = r_box3[i].yl + w_wy;
                n_box4[i].yh = r_box3[i].yh + w_wy;
            end
        end
    end

    always_comb begin
        t_clip c;
        for (int i = 0; i < C_LANES; i++) begin
            c         = clip_box(r_box4[i], SW, SH);
            n_box5[i] = c.box;
            n_en5[i]  = r_en4[i] && c.vis;
        end
    end

    always_comb begin
        t_crd d_row, d_run, d_rows;
        for (int i = 0; i < C_LANES; i++) begin
            d_row      = SHM1 - r_box5[i].yl;
            d_run      = r_box5[i].xh - r_box5[i].xl + t_crd'(1);
            d_rows     = r_box5[i].yh - r_box5[i].yl + t_crd'(1);
            n_x6[i]    = r_box5[i].xl[XW-1:0];
            n_row6[i]  = d_row[YW-1:0];
            n_run6[i]  = d_run[9:0];
            n_rows6[i] = d_rows[8:0];
        end
    end

    always_comb begin
        for (int i = 0; i < C_LANES; i++) begin
            n_prod7[i] = PW'(r_row6[i]) * PW'(WIDTH);
        end
    end

    always_comb begin
        for (int i = 0; i < C_LANES; i++) begin
            n_base8[i] = 21'({r_prod7[i] + PW'(r_x7[i]), 2'b00});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_cmd1 <= t_cmd'(s_axis_tuser[1:0]);
            r_rel1 <= s_axis_tuser[2];
            r_xf1  <= s_axis_tdata[15:0];
            r_yf1  <= s_axis_tdata[31:16];
            r_xs1  <= s_axis_tdata[47:32];
            r_ys1  <= s_axis_tdata[63:48];
            r_col1 <= {s_axis_tdata[71:64], s_axis_tdata[79:72], s_axis_tdata[87:80]};
        end
        if (w_rdy[2]) begin
            r_box2 <= n_box2;
            r_en2  <= n_en2;
            r_rel2 <= r_rel1;
            r_col2 <= r_col1;
        end
        if (w_rdy[3]) begin
            r_box3 <= n_box3;
            r_en3  <= n_en3;
            r_rel3 <= r_rel2;
            r_col3 <= r_col2;
        end
        if (w_rdy[4]) begin
            r_box4 <= n_box4;
            r_en4  <= r_en3;
            r_col4 <= r_col3;
        end
        if (w_rdy[5]) begin
            r_box5 <= n_box5;
            r_en5  <= n_en5;
            r_col5 <= r_col4;
        end
        if (w_rdy[6]) begin
            r_x6    <= n_x6;
            r_row6  <= n_row6;
            r_run6  <= n_run6;
            r_rows6 <= n_rows6;
            r_en6   <= r_en5;
            r_col6  <= r_col5;
        end
        if (w_rdy[7]) begin
            r_prod7 <= n_prod7;
            r_x7    <= r_x6;
            r_run7  <= r_run6;
            r_rows7 <= r_rows6;
            r_en7   <= r_en6;
            r_col7  <= r_col6;
        end
        if (w_rdy[8]) begin
            r_base8 <= n_base8;
            r_run8  <= r_run7;
            r_rows8 <= r_rows7;
            r_m8    <= r_en7;
            r_col8  <= r_col7;
        end else if (w_xfer) begin
            r_m8 <= w_rest;
        end
    end

    // The lowest lane still pending goes out next; the last one carries tlast.
    always_comb begin
        w_sel = '0;
        for (int i = C_LANES - 1; i >= 0; i--) begin
            if (r_m8[i]) w_sel = C_LW'(i);
        end
        w_rest = r_m8 & ~(C_LANES'(1) << w_sel);
    end

    assign m_axis_tvalid = r_v[8] && (|r_m8);
    assign m_axis_tlast  = ~|w_rest;
    assign m_axis_tdata  = {r_col8.blue, r_col8.green, r_col8.red,
                            r_rows8[w_sel], r_run8[w_sel], r_base8[w_sel]};
    assign w_xfer        = m_axis_tvalid && m_axis_tready;
    assign w_done8       = r_v[8] && ((~|r_m8) || (w_xfer && (~|w_rest)));

endmodule

`default_nettype wire

// File: hdl/cssr_checker.sv
// ----------------------------------------------------------------------------
// Clipped span setup checker
// Port-level checks on the descriptor stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cssr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cssr_pkg::C_OUT_DW-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);

    // Every descriptor address points at a whole 4-byte pixel.
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == 2'b00))
        else $error("descriptor address is not pixel aligned");

    // The remaining descriptors of a command follow without a gap.
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("descriptor run of a command was broken before tlast");

    a_hold_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("tvalid dropped while stalled");

    a_hold_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("descriptor changed while stalled");

endmodule

bind clipped_span_rect_setup_top cssr_checker u_cssr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
